[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Check a property at every rising clock edge, reset edges included.
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

[rtl/core/ccfa_pkg.sv]
// Types, constants and calendar functions of the calendar clock.
`default_nettype none

package ccfa_pkg;

   localparam int MILLIS_W = 10;
   localparam int SECOND_W = 6;
   localparam int MINUTE_W = 6;
   localparam int HOUR_W   = 5;
   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 14;
   localparam int MODE_W   = 2;
   localparam int FIELD_W  = 4;
   localparam int STEP_W   = 10;

   localparam int TIME_W   = MILLIS_W + SECOND_W + MINUTE_W + HOUR_W + DAY_W + MONTH_W + YEAR_W;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = ((TIME_W + 7) / 8) * 8;

   localparam logic [STEP_W-1:0]   STEP_RESET  = STEP_W'(200);
   localparam logic [STEP_W-1:0]   STEP_MAX    = STEP_W'(999);
   localparam logic [MILLIS_W:0]   MILLIS_WRAP = (MILLIS_W+1)'(1000);
   localparam logic [SECOND_W-1:0] SECOND_LAST = SECOND_W'(59);
   localparam logic [MINUTE_W-1:0] MINUTE_LAST = MINUTE_W'(59);
   localparam logic [HOUR_W-1:0]   HOUR_LAST   = HOUR_W'(23);
   localparam logic [MONTH_W-1:0]  MONTH_LAST  = MONTH_W'(12);
   localparam logic [MONTH_W-1:0]  MONTH_FEB   = MONTH_W'(2);
   localparam logic [YEAR_W-1:0]   YEAR_LAST   = YEAR_W'(9999);
   localparam logic [DAY_W-1:0]    DAYS_LEAP_FEB = DAY_W'(29);
   localparam logic [DAY_W-1:0]    DAYS_DEFAULT  = DAY_W'(31);

   // Days per month, January first.
   localparam logic [DAY_W-1:0] MONTH_DAYS [12] = '{
      DAY_W'(31), DAY_W'(28), DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(30),
      DAY_W'(31), DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(30), DAY_W'(31)
   };

   // Divisibility by 25: y * 5243 = y/25 * 2^17 + small rest when 25 divides y.
   localparam int               DIV25_W   = 17;
   localparam logic [DIV25_W-1:0] DIV25_MUL = DIV25_W'(5243);

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK = 2'd0,
      MODE_UP   = 2'd1,
      MODE_DOWN = 2'd2
   } mode_type;

   typedef enum logic [FIELD_W-1:0] {
      FIELD_HOUR       = 4'd0,
      FIELD_MINUTE     = 4'd1,
      FIELD_SECOND     = 4'd2,
      FIELD_DAY        = 4'd3,
      FIELD_MONTH      = 4'd4,
      FIELD_YEAR       = 4'd5,
      FIELD_DECADE     = 4'd6,
      FIELD_CENTURY    = 4'd7,
      FIELD_MILLENNIUM = 4'd8
   } field_type;

   // Calendar state, milliseconds in the lowest bits.
   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
      logic [MILLIS_W-1:0] millis;
   } time_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [FIELD_W-1:0] field_select;
   } req_type;

   localparam time_type TIME_RESET = '{
      year:   YEAR_W'(2024),
      month:  MONTH_W'(4),
      day:    DAY_W'(17),
      hour:   HOUR_W'(4),
      minute: MINUTE_W'(20),
      second: SECOND_W'(0),
      millis: MILLIS_W'(0)
   };

   function automatic logic is_leap(input logic [YEAR_W-1:0] year);
      logic [YEAR_W+DIV25_W-1:0] prod;
      logic                      div25;
      logic                      div16;
      prod  = (YEAR_W+DIV25_W)'(year) * (YEAR_W+DIV25_W)'(DIV25_MUL);
      div25 = prod[DIV25_W-1:0] < DIV25_MUL;
      div16 = (year[3:0] == 4'd0);
      // Multiple of 4, and not a century unless also a multiple of 400.
      return (year[1:0] == 2'd0) && (!div25 || div16);
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic [YEAR_W-1:0]  year);
      logic [DAY_W-1:0] len;
      if (month == MONTH_FEB && is_leap(year)) begin
         len = DAYS_LEAP_FEB;
      end else if (month == '0 || month > MONTH_LAST) begin
         len = DAYS_DEFAULT;
      end else begin
         len = MONTH_DAYS[MONTH_W'(month - MONTH_W'(1))];
      end
      return len;
   endfunction

   function automatic logic [YEAR_W-1:0] year_amount(input logic [FIELD_W-1:0] sel);
      logic [YEAR_W-1:0] amt;
      case (sel)
         FIELD_YEAR:       amt = YEAR_W'(1);
         FIELD_DECADE:     amt = YEAR_W'(10);
         FIELD_CENTURY:    amt = YEAR_W'(100);
         FIELD_MILLENNIUM: amt = YEAR_W'(1000);
         default:          amt = '0;
      endcase
      return amt;
   endfunction

endpackage

`default_nettype wire

[rtl/core/ccfa_in_stage.sv]
// Input register slice of the calendar clock.
`default_nettype none

module ccfa_in_stage
   import ccfa_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire req_type in_item,
   input  wire logic    take,
   output logic         out_valid,
   output req_type      out_item
);

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;
   logic    load;

   // Refill in the same cycle the held item moves on.
   assign in_ready = !valid_ff || take;
   assign load     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= in_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

[rtl/core/ccfa_update.sv]
// Next calendar state for one tick or adjust item.
`default_nettype none

module ccfa_update
   import ccfa_pkg::*;
(
   input  wire time_type          cur,
   input  wire req_type           item,
   input  wire logic [STEP_W-1:0] step,
   output time_type               nxt,
   output logic                   rolled
);

   logic [STEP_W-1:0]   step_c;
   logic [MILLIS_W:0]   millis_sum;
   logic [DAY_W-1:0]    len;
   logic [DAY_W:0]      day_inc;
   logic [YEAR_W-1:0]   amt;
   logic [YEAR_W:0]     year_up;
   logic                up;

   assign step_c     = (step > STEP_MAX) ? STEP_MAX : step;
   assign millis_sum = (MILLIS_W+1)'(cur.millis) + (MILLIS_W+1)'(step_c);
   assign len        = month_len(cur.month, cur.year);
   assign day_inc    = (DAY_W+1)'(cur.day) + (DAY_W+1)'(1);
   assign amt        = year_amount(item.field_select);
   assign year_up    = (YEAR_W+1)'(cur.year) + (YEAR_W+1)'(amt);
   assign up         = (item.mode == MODE_UP);

   always_comb begin
      nxt    = cur;
      rolled = 1'b0;
      case (item.mode)
         MODE_TICK: begin
            if (millis_sum >= MILLIS_WRAP) begin
               rolled     = 1'b1;
               nxt.millis = MILLIS_W'(millis_sum - MILLIS_WRAP);
               if (cur.second >= SECOND_LAST) begin
                  nxt.second = '0;
                  if (cur.minute >= MINUTE_LAST) begin
                     nxt.minute = '0;
                     if (cur.hour >= HOUR_LAST) begin
                        nxt.hour = '0;
                        if (day_inc > (DAY_W+1)'(len)) begin
                           nxt.day = DAY_W'(1);
                           if (cur.month >= MONTH_LAST) begin
                              nxt.month = MONTH_W'(1);
                              if (cur.year < YEAR_LAST) begin
                                 nxt.year = cur.year + YEAR_W'(1);
                              end
                           end else begin
                              nxt.month = cur.month + MONTH_W'(1);
                           end
                        end else begin
                           nxt.day = DAY_W'(day_inc);
                        end
                     end else begin
                        nxt.hour = cur.hour + HOUR_W'(1);
                     end
                  end else begin
                     nxt.minute = cur.minute + MINUTE_W'(1);
                  end
               end else begin
                  nxt.second = cur.second + SECOND_W'(1);
               end
            end else begin
               nxt.millis = MILLIS_W'(millis_sum);
            end
         end
         MODE_UP, MODE_DOWN: begin
            case (item.field_select)
               FIELD_HOUR: begin
                  if (up) begin
                     nxt.hour = (cur.hour >= HOUR_LAST) ? '0 : cur.hour + HOUR_W'(1);
                  end else begin
                     nxt.hour = (cur.hour == '0) ? HOUR_LAST : cur.hour - HOUR_W'(1);
                  end
               end
               FIELD_MINUTE: begin
                  if (up) begin
                     nxt.minute = (cur.minute >= MINUTE_LAST) ? '0
                                                              : cur.minute + MINUTE_W'(1);
                  end else begin
                     nxt.minute = (cur.minute == '0) ? MINUTE_LAST
                                                     : cur.minute - MINUTE_W'(1);
                  end
               end
               FIELD_SECOND: begin
                  if (up) begin
                     nxt.second = (cur.second >= SECOND_LAST) ? '0
                                                              : cur.second + SECOND_W'(1);
                  end else begin
                     nxt.second = (cur.second == '0) ? SECOND_LAST
                                                     : cur.second - SECOND_W'(1);
                  end
               end
               FIELD_DAY: begin
                  if (up) begin
                     nxt.day = (day_inc > (DAY_W+1)'(len)) ? DAY_W'(1) : DAY_W'(day_inc);
                  end else begin
                     nxt.day = (cur.day <= DAY_W'(1)) ? len : cur.day - DAY_W'(1);
                  end
               end
               FIELD_MONTH: begin
                  if (up) begin
                     nxt.month = (cur.month >= MONTH_LAST) ? MONTH_W'(1)
                                                           : cur.month + MONTH_W'(1);
                  end else begin
                     nxt.month = (cur.month <= MONTH_W'(1)) ? MONTH_LAST
                                                            : cur.month - MONTH_W'(1);
                  end
               end
               FIELD_YEAR, FIELD_DECADE, FIELD_CENTURY, FIELD_MILLENNIUM: begin
                  // Saturate at both ends.
                  if (up) begin
                     nxt.year = (year_up > (YEAR_W+1)'(YEAR_LAST)) ? YEAR_LAST
                                                                 : YEAR_W'(year_up);
                  end else begin
                     nxt.year = (cur.year < amt) ? '0 : cur.year - amt;
                  end
               end
               default: begin
                  nxt = cur;
               end
            endcase
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/core/calendar_clock_with_field_adjust.sv]
// Top level of the calendar clock with tick and single-field adjust.
`default_nettype none

// Real-time clock and calendar. Every request item is a tick (mode 0), which
// adds the programmed step (csr_wr_data, reset 200, values above 999 act as
// 999) to the milliseconds and carries into seconds, minutes, hours, day,
// month and year with Gregorian month lengths, or an adjust (mode 1 up,
// mode 2 down) that moves the field chosen by req_tuser with wrap-around;
// the year, decade, century and millennium adjusts move the year by 1, 10,
// 100 or 1000 and saturate at 0 and 9999. Mode 3 and adjusts with field codes
// 9 to 15 leave the state as it is. Each item yields exactly one response item
// with the updated date and time and a flag that is set when a tick carried
// into the seconds. The block accepts one item per clock while responses are
// taken; a stalled response holds the input back. An accepted item waits in
// the input register, then the whole carry chain and leap-year test settle
// combinationally into the response register, which also commits the calendar
// state. Write the step register only while no item is in flight. After reset
// the clock reads 04:20:00.000 on 17 April 2024.

module calendar_clock_with_field_adjust
   import ccfa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [1:0] mode, rest zero
   input  wire logic [FIELD_W-1:0]    req_tuser,   // [3:0] field_select
   // Response channel.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [9:0] millis_now, [15:10] seconds_now,
                                                   // [21:16] minutes_now, [26:22] hours_now,
                                                   // [31:27] day_now, [35:32] month_now,
                                                   // [49:36] year_now, rest zero
   output logic                       rsp_tuser,   // [0] second_rolled
   // Step register write port.
   input  wire logic                  csr_wr_en,
   input  wire logic [STEP_W-1:0]     csr_wr_data
);

   // Step register.
   logic [STEP_W-1:0] step_ff;

   // Input register.
   req_type req_item;
   req_type s1_item;
   logic    s1_valid;
   logic    s1_take;

   // Calendar state and response register.
   time_type state_ff;
   time_type state_in;
   logic     rolled_in;
   time_type out_time_ff;
   logic     out_rolled_ff;
   logic     out_valid_ff;
   logic     out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
      end else if (csr_wr_en) begin
         step_ff <= csr_wr_data;
      end
   end

   assign req_item.mode         = req_tdata[MODE_W-1:0];
   assign req_item.field_select = req_tuser;

   ccfa_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .take      (s1_take),
      .out_valid (s1_valid),
      .out_item  (s1_item)
   );

   // Advance when the response register is empty or being drained this cycle.
   assign s1_take = s1_valid && (!out_valid_ff || rsp_tready);

   ccfa_update u_update (
      .cur    (state_ff),
      .item   (s1_item),
      .step   (step_ff),
      .nxt    (state_in),
      .rolled (rolled_in)
   );

   // Commit the calendar only as the item's response is captured.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TIME_RESET;
      end else if (s1_take) begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_take) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         out_time_ff   <= state_in;
         out_rolled_ff <= rolled_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(out_time_ff);
   assign rsp_tuser  = out_rolled_ff;

endmodule

`default_nettype wire

[rtl/core/ccfa_checker.sv]
// Port-level checks of the calendar clock and their binding to the top level.
`default_nettype none

`include "assert_macros.svh"

module ccfa_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [55:0] rsp_tdata,
   input wire logic        rsp_tuser
);

   logic [9:0]  millis_now;
   logic [5:0]  seconds_now;
   logic [5:0]  minutes_now;
   logic [4:0]  hours_now;
   logic [4:0]  day_now;
   logic [3:0]  month_now;
   logic [13:0] year_now;
   logic        in_range;

   assign millis_now  = rsp_tdata[9:0];
   assign seconds_now = rsp_tdata[15:10];
   assign minutes_now = rsp_tdata[21:16];
   assign hours_now   = rsp_tdata[26:22];
   assign day_now     = rsp_tdata[31:27];
   assign month_now   = rsp_tdata[35:32];
   assign year_now    = rsp_tdata[49:36];

   assign in_range = (millis_now < 10'd1000) && (seconds_now < 6'd60)
                  && (minutes_now < 6'd60) && (hours_now < 5'd24)
                  && (day_now != 5'd0) && (month_now != 4'd0)
                  && (month_now <= 4'd12) && (year_now <= 14'd9999);

   // Reset empties the response register.
   `ASSERT_CLK(a_reset_empties, clock, reset |=> !rsp_tvalid)

   // The carry chain never leaves a field outside its range.
   `ASSERT_CLK_RST(a_fields_in_range, clock, reset, rsp_tvalid |-> in_range)

   // A second carry leaves at most 998 milliseconds.
   `ASSERT_CLK_RST(a_roll_millis, clock, reset,
      rsp_tvalid && rsp_tuser |-> millis_now < 10'd999)

   // A stalled response holds.
   `ASSERT_CLK_RST(a_stall_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

endmodule

bind calendar_clock_with_field_adjust ccfa_checker u_ccfa_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

[sim/tb_calendar_clock_with_field_adjust.sv]
// Self-checking testbench of the calendar clock: directed table, then planned random bursts.
`timescale 1ns / 100ps

module tb_calendar_clock_with_field_adjust;
   import ccfa_pkg::*;

   // Codes the block must ignore: the spare mode and the field codes past the millennium.
   localparam logic [MODE_W-1:0]  MODE_NONE    = 2'd3;
   localparam logic [FIELD_W-1:0] FIELD_BAD_LO = 4'd9;
   localparam logic [FIELD_W-1:0] FIELD_BAD_HI = 4'd15;

   // Calendar arithmetic.
   localparam int MS_PER_SEC      = 1000;
   localparam int SEC_PER_MIN     = 60;
   localparam int MIN_PER_HOUR    = 60;
   localparam int HOURS_PER_DAY   = 24;
   localparam int MONTHS_PER_YEAR = 12;
   localparam int YEAR_TOP        = 9999;
   localparam int STEP_CLAMP      = 999;
   localparam int LEAP_FEB_DAYS   = 29;
   localparam int DAYS_PER_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   // Run shaping.
   localparam int RESET_CYCLES    = 5;
   localparam int IDLE_PCT        = 30;
   localparam int HOLD_AT         = 150;
   localparam int RSP_HOLD_CYCLES = 80;
   localparam int QUIET_FROM      = 280;
   localparam int QUIET_TO        = 360;
   localparam int SETTLE_CYCLES   = 4;
   localparam int DRAIN_CYCLES    = 10;
   localparam int NUM_PHASES      = 6;
   localparam int ITEMS_PER_PHASE = 62;
   localparam int FIXED_STEPS [4] = '{999, 1, 1023, 0};
   localparam int LIMIT_NS        = 4_000_000;

   // Wide enough that a day past the month end can count one further before it wraps.
   typedef struct packed {
      int millis;
      int second;
      int minute;
      int hour;
      int day;
      int month;
      int year;
   } cal_state_t;

   typedef struct packed {
      time_type stamp;
      logic     rolled;
   } clock_reading_t;

   typedef struct packed {
      req_type  req;
      logic     known;
      time_type stamp;
      logic     rolled;
   } planned_item_t;

   localparam cal_state_t RESET_STATE = '{0, 0, 20, 4, 17, 4, 2024};
   localparam time_type   NO_STAMP    = '0;

   // Directed rows. Stamps are positional: year, month, day, hour, minute, second, millis.
   // Rows with known cleared are checked against the predictor.
   localparam planned_item_t DIRECTED_ITEMS [25] = '{
      '{'{MODE_NONE,  FIELD_HOUR},   1'b1, TIME_RESET, 1'b0},
      '{'{MODE_TICK,  FIELD_HOUR},   1'b1,
        '{14'd2024, 4'd4, 5'd17, 5'd4, 6'd20, 6'd0, 10'd200}, 1'b0},
      '{'{MODE_TICK,  FIELD_HOUR},   1'b0, NO_STAMP, 1'b0},
      '{'{MODE_TICK,  FIELD_BAD_HI}, 1'b0, NO_STAMP, 1'b0},
      '{'{MODE_TICK,  FIELD_DAY},    1'b0, NO_STAMP, 1'b0},
      '{'{MODE_TICK,  FIELD_HOUR},   1'b1,
        '{14'd2024, 4'd4, 5'd17, 5'd4, 6'd20, 6'd1, 10'd0}, 1'b1},
      '{'{MODE_UP,    FIELD_BAD_LO}, 1'b1,
        '{14'd2024, 4'd4, 5'd17, 5'd4, 6'd20, 6'd1, 10'd0}, 1'b0},
      '{'{MODE_DOWN,  FIELD_BAD_HI}, 1'b0, NO_STAMP, 1'b0},
      '{'{MODE_DOWN,  FIELD_SECOND}, 1'b0, NO_STAMP, 1'b0},
      '{'{MODE_DOWN,  FIELD_SECOND}, 1'b1,
        '{14'd2024, 4'd4, 5'd17, 5'd4, 6'd20, 6'd59, 10'd0}, 1'b0},
      '{'{MODE_UP,    FIELD_SECOND},     1'b0, NO_STAMP, 1'b0},
      '{'{MODE_DOWN,  FIELD_MINUTE},     1'b0, NO_STAMP, 1'b0},
      '{'{MODE_UP,    FIELD_MINUTE},     1'b0, NO_STAMP, 1'b0},
      '{'{MODE_UP,    FIELD_HOUR},       1'b0, NO_STAMP, 1'b0},
      '{'{MODE_DOWN,  FIELD_HOUR},       1'b0, NO_STAMP, 1'b0},
      '{'{MODE_DOWN,  FIELD_DAY},        1'b0, NO_STAMP, 1'b0},
      '{'{MODE_UP,    FIELD_DAY},        1'b0, NO_STAMP, 1'b0},
      '{'{MODE_DOWN,  FIELD_MONTH},      1'b0, NO_STAMP, 1'b0},
      '{'{MODE_UP,    FIELD_MONTH},      1'b0, NO_STAMP, 1'b0},
      '{'{MODE_UP,    FIELD_YEAR},       1'b0, NO_STAMP, 1'b0},
      '{'{MODE_DOWN,  FIELD_DECADE},     1'b0, NO_STAMP, 1'b0},
      '{'{MODE_UP,    FIELD_CENTURY},    1'b0, NO_STAMP, 1'b0},
      '{'{MODE_DOWN,  FIELD_MILLENNIUM}, 1'b0, NO_STAMP, 1'b0},
      '{'{MODE_DOWN,  FIELD_MILLENNIUM}, 1'b0, NO_STAMP, 1'b0},
      '{'{MODE_DOWN,  FIELD_MILLENNIUM}, 1'b1,
        '{14'd0, 4'd4, 5'd17, 5'd4, 6'd20, 6'd0, 10'd0}, 1'b0}
   };

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;   // [1:0] mode, rest zero
   logic [FIELD_W-1:0]    req_tuser   = '0;   // [3:0] field_select
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // [9:0] millis, [15:10] seconds, [21:16] minutes,
                                              // [26:22] hours, [31:27] day, [35:32] month,
                                              // [49:36] year, rest zero
   logic                  rsp_tuser;          // [0] second_rolled
   logic                  csr_wr_en   = 1'b0;
   logic [STEP_W-1:0]     csr_wr_data = '0;

   // Predictor state advances on acceptance; planner state advances as items are queued.
   cal_state_t        model_state;
   cal_state_t        plan_state;
   logic [STEP_W-1:0] step_reg;
   clock_reading_t    expected_readings [$];
   planned_item_t     pending_items [$];
   int                sent_items      = 0;
   int                planned_payload = 0;
   int                mismatch_count  = 0;

   calendar_clock_with_field_adjust u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Gregorian rule: every fourth year, centuries only when they divide by 400.
   function automatic int days_in_month(input int month, input int year);
      if (month == int'(MONTH_FEB) && (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0)))
         return LEAP_FEB_DAYS;
      if (month < 1 || month > MONTHS_PER_YEAR)
         return DAYS_PER_MONTH[0];
      return DAYS_PER_MONTH[month - 1];
   endfunction

   // Apply one item to a calendar state; return the second carry flag.
   function automatic logic advance_clock(inout cal_state_t s, input int step_setting,
                                          input logic [MODE_W-1:0]  mode,
                                          input logic [FIELD_W-1:0] sel);
      int   step;
      int   len;
      int   amount;
      logic up;
      logic rolled;
      rolled = 1'b0;
      up     = (mode == MODE_UP);
      step   = (step_setting > STEP_CLAMP) ? STEP_CLAMP : step_setting;
      if (mode == MODE_TICK) begin
         s.millis += step;
         if (s.millis >= MS_PER_SEC) begin
            rolled    = 1'b1;
            s.millis -= MS_PER_SEC;
            s.second++;
            if (s.second >= SEC_PER_MIN) begin
               s.second = 0;
               s.minute++;
               if (s.minute >= MIN_PER_HOUR) begin
                  s.minute = 0;
                  s.hour++;
                  if (s.hour >= HOURS_PER_DAY) begin
                     s.hour = 0;
                     s.day++;
                     if (s.day > days_in_month(s.month, s.year)) begin
                        s.day = 1;
                        s.month++;
                        if (s.month > MONTHS_PER_YEAR) begin
                           s.month = 1;
                           if (s.year < YEAR_TOP) s.year++;
                        end
                     end
                  end
               end
            end
         end
      end else if (mode == MODE_UP || mode == MODE_DOWN) begin
         amount = 0;
         case (sel)
            FIELD_HOUR: begin
               if (up) s.hour = (s.hour >= HOURS_PER_DAY - 1) ? 0 : s.hour + 1;
               else    s.hour = (s.hour == 0) ? HOURS_PER_DAY - 1 : s.hour - 1;
            end
            FIELD_MINUTE: begin
               if (up) s.minute = (s.minute >= MIN_PER_HOUR - 1) ? 0 : s.minute + 1;
               else    s.minute = (s.minute == 0) ? MIN_PER_HOUR - 1 : s.minute - 1;
            end
            FIELD_SECOND: begin
               if (up) s.second = (s.second >= SEC_PER_MIN - 1) ? 0 : s.second + 1;
               else    s.second = (s.second == 0) ? SEC_PER_MIN - 1 : s.second - 1;
            end
            FIELD_DAY: begin
               len = days_in_month(s.month, s.year);
               if (up) s.day = (s.day + 1 > len) ? 1 : s.day + 1;
               else    s.day = (s.day <= 1) ? len : s.day - 1;
            end
            FIELD_MONTH: begin
               if (up) s.month = (s.month >= MONTHS_PER_YEAR) ? 1 : s.month + 1;
               else    s.month = (s.month <= 1) ? MONTHS_PER_YEAR : s.month - 1;
            end
            FIELD_YEAR:       amount = 1;
            FIELD_DECADE:     amount = 10;
            FIELD_CENTURY:    amount = 100;
            FIELD_MILLENNIUM: amount = 1000;
            default: ;
         endcase
         // Year moves saturate rather than wrap.
         if (amount != 0) begin
            if (up) s.year = (s.year + amount > YEAR_TOP) ? YEAR_TOP : s.year + amount;
            else    s.year = (s.year < amount) ? 0 : s.year - amount;
         end
      end
      return rolled;
   endfunction

   // No idling on either side while this is true.
   function automatic bit quiet_stretch();
      return sent_items >= QUIET_FROM && sent_items < QUIET_TO;
   endfunction

   // Offer one item, hold it until accepted, then record what the block must answer.
   task automatic drive_item(input planned_item_t p);
      logic rolled;
      if (!quiet_stretch() && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while (!quiet_stretch() && $urandom_range(99) < IDLE_PCT);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(p.req.mode);
      req_tuser  <= p.req.field_select;
      do @(posedge clock); while (!req_tready);
      rolled = advance_clock(model_state, int'(step_reg), p.req.mode, p.req.field_select);
      if (p.known) begin
         expected_readings.push_back('{p.stamp, p.rolled});
      end else begin
         expected_readings.push_back('{'{YEAR_W'(model_state.year), MONTH_W'(model_state.month),
                                         DAY_W'(model_state.day), HOUR_W'(model_state.hour),
                                         MINUTE_W'(model_state.minute),
                                         SECOND_W'(model_state.second),
                                         MILLIS_W'(model_state.millis)}, rolled});
      end
      sent_items++;
   endtask

   // Queue one random-part item and advance the planner with it.
   task automatic push_planned(input logic [MODE_W-1:0] mode, input logic [FIELD_W-1:0] sel);
      planned_item_t p;
      p = '{'{mode, sel}, 1'b0, NO_STAMP, 1'b0};
      void'(advance_clock(plan_state, int'(step_reg), mode, sel));
      pending_items.push_back(p);
      // Ignored items do not count toward the phase length.
      if (mode == MODE_TICK ||
          ((mode == MODE_UP || mode == MODE_DOWN) && sel <= FIELD_MILLENNIUM))
         planned_payload++;
   endtask

   function automatic int field_now(input logic [FIELD_W-1:0] sel);
      case (sel)
         FIELD_HOUR:   return plan_state.hour;
         FIELD_MINUTE: return plan_state.minute;
         FIELD_SECOND: return plan_state.second;
         FIELD_DAY:    return plan_state.day;
         default:      return plan_state.month;
      endcase
   endfunction

   // Walk one wrapping field to a target the short way round.
   task automatic steer_field(input logic [FIELD_W-1:0] sel, input int target);
      int                lo;
      int                hi;
      int                span;
      int                fwd;
      int                guard;
      logic [MODE_W-1:0] dir;
      lo = (sel == FIELD_DAY || sel == FIELD_MONTH) ? 1 : 0;
      case (sel)
         FIELD_HOUR:  hi = HOURS_PER_DAY - 1;
         FIELD_DAY:   hi = days_in_month(plan_state.month, plan_state.year);
         FIELD_MONTH: hi = MONTHS_PER_YEAR;
         default:     hi = SEC_PER_MIN - 1;
      endcase
      span = hi - lo + 1;
      fwd  = ((target - field_now(sel)) % span + span) % span;
      // A day past the month end only comes back through an increment.
      dir  = (field_now(sel) > hi || 2 * fwd <= span) ? MODE_UP : MODE_DOWN;
      guard = 0;
      while (field_now(sel) != target && guard < 64) begin
         push_planned(dir, sel);
         guard++;
      end
   endtask

   // Reach a year with the coarsest moves; the ends are reached by saturating.
   task automatic steer_year(input int target);
      int                 diff;
      int                 gap;
      int                 guard;
      logic [FIELD_W-1:0] sel;
      guard = 0;
      while (plan_state.year != target && guard < 64) begin
         diff = target - plan_state.year;
         gap  = (diff < 0) ? -diff : diff;
         if (target == YEAR_TOP || target == 0 || gap >= 1000) sel = FIELD_MILLENNIUM;
         else if (gap >= 100)                                  sel = FIELD_CENTURY;
         else if (gap >= 10)                                   sel = FIELD_DECADE;
         else                                                  sel = FIELD_YEAR;
         push_planned((diff > 0) ? MODE_UP : MODE_DOWN, sel);
         guard++;
      end
   endtask

   // Years with leap-rule or saturation interest.
   function automatic int pick_year();
      case ($urandom_range(7))
         0:       return YEAR_TOP;
         1:       return 2000;
         2:       return 1900;
         3:       return 2100;
         4:       return 2023;
         5:       return 0;
         6:       return 2024;
         default: return $urandom_range(YEAR_TOP);
      endcase
   endfunction

   // Set 23:59:59 and tick from there, across midnight when the step is large enough.
   task automatic approach_midnight();
      int n;
      steer_field(FIELD_HOUR, HOURS_PER_DAY - 1);
      steer_field(FIELD_MINUTE, MIN_PER_HOUR - 1);
      steer_field(FIELD_SECOND, SEC_PER_MIN - 1);
      n = $urandom_range(1, 12);
      repeat (n) push_planned(MODE_TICK, FIELD_W'($urandom_range(15)));
   endtask

   // Plan one burst of random-part items.
   task automatic plan_burst();
      int n;
      int month;
      case ($urandom_range(9))
         0, 1: begin
            // Noise: any mode and any field code, ignored ones included.
            n = $urandom_range(1, 6);
            repeat (n) push_planned(MODE_W'($urandom_range(3)), FIELD_W'($urandom_range(15)));
         end
         2, 3, 4: begin
            // Roll over a day, often a month end, sometimes a year end or a leap February.
            if ($urandom_range(4) == 0) steer_year(pick_year());
            case ($urandom_range(3))
               0: steer_field(FIELD_MONTH, MONTHS_PER_YEAR);
               1: steer_field(FIELD_MONTH, int'(MONTH_FEB));
               default: ;
            endcase
            if ($urandom_range(1))
               steer_field(FIELD_DAY, days_in_month(plan_state.month, plan_state.year)
                                      - $urandom_range(1));
            approach_midnight();
         end
         5: begin
            // Leave day 31 standing in a shorter month, then move the day or tick toward midnight.
            case ($urandom_range(4))
               0: month = 1;
               1: month = 3;
               2: month = 5;
               3: month = 8;
               default: month = 10;
            endcase
            if ($urandom_range(1)) steer_year(pick_year());
            steer_field(FIELD_MONTH, month);
            steer_field(FIELD_DAY, 31);
            push_planned(MODE_UP, FIELD_MONTH);
            if ($urandom_range(1)) push_planned($urandom_range(1) ? MODE_UP : MODE_DOWN, FIELD_DAY);
            else approach_midnight();
         end
         6, 7: begin
            n = $urandom_range(1, 10);
            repeat (n) push_planned(MODE_W'($urandom_range(1, 2)), FIELD_W'($urandom_range(8)));
         end
         default: begin
            n = $urandom_range(1, 20);
            repeat (n) push_planned(MODE_TICK, FIELD_W'($urandom_range(15)));
         end
      endcase
   endtask

   // Receiver: random stalls, one long hold-off that backs the block up, one quiet stretch.
   initial begin : rsp_ready_gen
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && sent_items >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = RSP_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet_stretch() || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Compare every accepted reading with the oldest expectation.
   always @(posedge clock) begin : reading_check
      clock_reading_t want;
      time_type       got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[TIME_W-1:0];
         if (expected_readings.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: reading with nothing expected: %0d-%0d-%0d %0d:%0d:%0d.%0d",
                        $time, got.year, got.month, got.day, got.hour, got.minute,
                        got.second, got.millis);
         end else begin
            want = expected_readings.pop_front();
            if (got.millis != want.stamp.millis || got.second != want.stamp.second ||
                got.minute != want.stamp.minute || got.hour != want.stamp.hour ||
                got.day != want.stamp.day || got.month != want.stamp.month ||
                got.year != want.stamp.year || rsp_tuser != want.rolled) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"%0t: expected %0d-%0d-%0d %0d:%0d:%0d.%0d roll %0b,",
                            " got %0d-%0d-%0d %0d:%0d:%0d.%0d roll %0b"}, $time,
                           want.stamp.year, want.stamp.month, want.stamp.day,
                           want.stamp.hour, want.stamp.minute, want.stamp.second,
                           want.stamp.millis, want.rolled,
                           got.year, got.month, got.day, got.hour, got.minute,
                           got.second, got.millis, rsp_tuser);
            end
         end
      end
   end

   // Stimulus: reset, directed table, then one random phase per step setting.
   initial begin : stimulus
      int step_value;
      model_state = RESET_STATE;
      plan_state  = RESET_STATE;
      step_reg    = STEP_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part runs on the reset step.
      foreach (DIRECTED_ITEMS[i]) begin
         void'(advance_clock(plan_state, int'(step_reg), DIRECTED_ITEMS[i].req.mode,
                             DIRECTED_ITEMS[i].req.field_select));
         drive_item(DIRECTED_ITEMS[i]);
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         // Drain everything before touching the step register, then let the pipe settle.
         req_tvalid <= 1'b0;
         while (expected_readings.size() != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
         step_value = (phase < 4) ? FIXED_STEPS[phase] : $urandom_range(2, 998);
         csr_wr_en   <= 1'b1;
         csr_wr_data <= STEP_W'(step_value);
         @(posedge clock);
         csr_wr_en <= 1'b0;
         step_reg   = STEP_W'(step_value);

         planned_payload = 0;
         while (planned_payload < ITEMS_PER_PHASE) begin
            plan_burst();
            while (pending_items.size() != 0) drive_item(pending_items.pop_front());
         end
      end

      // Wait out the last readings, then keep watching for stray output.
      req_tvalid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_readings.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Hard stop for a hung handshake.
   initial begin : watchdog
      #(LIMIT_NS);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
